### rtl/apq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_pkg: shared types and constants for the array priority queue
// Field widths, action and status codes, default table depth.
// ----------------------------------------------------------------------------
package apq_pkg;

  localparam int unsigned ValW          = 32;
  localparam int unsigned PriW          = 32;
  localparam int unsigned HeldW         = 8;
  localparam int unsigned DEFAULT_DEPTH = 128;

  // action field codes
  localparam logic ActEnq = 1'b0;
  localparam logic ActDeq = 1'b1;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

endpackage

### rtl/apq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_if: valid/ready channels of the array priority queue
// Request channel (enqueue/dequeue) and response channel.
// ----------------------------------------------------------------------------
interface apq_in_if import apq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic signed [ValW-1:0] item_value;
  logic signed [PriW-1:0] item_priority;

  modport source (output valid, action, item_value, item_priority, input ready);
  modport sink   (input valid, action, item_value, item_priority, output ready);
endinterface

interface apq_out_if import apq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] out_value;
  logic                   out_valid;
  status_e                status;
  logic [HeldW-1:0]       held_count;

  modport source (output valid, out_value, out_valid, status, held_count, input ready);
  modport sink   (input valid, out_value, out_valid, status, held_count, output ready);
endinterface

### rtl/array_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_priority_queue_top: priority queue held as an unsorted table
// Enqueue appends at the tail; dequeue scans for the highest signed priority
// (earliest wins on ties), returns its value and shifts later entries down.
// ----------------------------------------------------------------------------
//
//  channel | dir | word                                        | accepted when
//  --------+-----+---------------------------------------------+--------------
//  in_i    | in  | action, item_value, item_priority            | valid & ready
//  out_o   | out | out_value, out_valid, status, held_count     | valid & ready
//
//  Enqueue: accept, then result hand-off in SFin. Dequeue: SScan over all held
//  entries, SShSet, SShift from the winner's slot to the tail, then SFin.
//  The single read port of the table RAM reads one entry per cycle in the
//  scan, then one entry per cycle in the shift-down.
//  Reset clears the entry count and control; the table RAM holds no reset.
//  in_i.ready is high only when the sequencer is idle. A finished word waits
//  in a result register while out_o stalls, and in_i.ready stays low until it moves on.
// ----------------------------------------------------------------------------
module array_priority_queue_top import apq_pkg::*; #(
  parameter int unsigned DEPTH = DEFAULT_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  apq_in_if.sink    in_i,
  apq_out_if.source out_o
);

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned MemW  = ValW + PriW;

  typedef enum logic [2:0] {
    SIdle,
    SScan,
    SShSet,
    SShift,
    SFin
  } state_e;

  state_e                 state_q;
  logic [CntW-1:0]        cnt_q;
  logic [CntW-1:0]        idx_q;       // scan index, then shift write index
  logic [CntW-1:0]        best_idx_q;
  logic signed [PriW-1:0] best_pri_q;
  logic [ValW-1:0]        best_val_q;
  logic                   first_q;

  // finished result, waiting for the output register
  logic [ValW-1:0]        res_val_q;
  logic                   res_ok_q;
  status_e                res_st_q;

  // output register
  logic                   ovld_q;
  logic [ValW-1:0]        oval_q;
  logic                   ook_q;
  status_e                ost_q;
  logic [HeldW-1:0]       ocnt_q;

  // table RAM: {value, priority}
  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr;
  logic [MemW-1:0]        ram_wdata;
  logic [AddrW-1:0]       ram_raddr;
  logic [MemW-1:0]        ram_rdata;
  logic [CntW:0]          raddr_full;

  logic                   accept;
  logic                   is_full;
  logic [CntW-1:0]        last_idx;
  logic                   last_hit;
  logic signed [PriW-1:0] rd_pri;
  logic [ValW-1:0]        rd_val;
  logic                   take;

  apq_ram #(
    .Width (MemW),
    .Depth (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready = (state_q == SIdle);
  assign accept     = in_i.valid && (state_q == SIdle);
  assign is_full    = (cnt_q == CntW'(DEPTH));
  assign last_idx   = cnt_q - CntW'(1);
  assign last_hit   = (idx_q == last_idx);

  assign rd_val = ram_rdata[MemW-1:PriW];
  assign rd_pri = $signed(ram_rdata[PriW-1:0]);

  // scan comparator: first entry always taken, later ones only if strictly higher
  assign take = first_q || (rd_pri > best_pri_q);

  // read address: next entry of the scan or of the shift stream
  always_comb begin
    case (state_q)
      SScan:   raddr_full = {1'b0, idx_q} + (CntW + 1)'(1);
      SShSet:  raddr_full = {1'b0, best_idx_q} + (CntW + 1)'(1);
      SShift:  raddr_full = {1'b0, idx_q} + (CntW + 1)'(2);
      default: raddr_full = '0;
    endcase
  end
  assign ram_raddr = raddr_full[AddrW-1:0];

  // write: enqueue at the tail, or move entry idx+1 down to idx
  always_comb begin
    if (state_q == SIdle) begin
      ram_we    = accept && (in_i.action == ActEnq) && !is_full;
      ram_waddr = cnt_q[AddrW-1:0];
      ram_wdata = {in_i.item_value, in_i.item_priority};
    end else begin
      ram_we    = (state_q == SShift) && !last_hit;
      ram_waddr = idx_q[AddrW-1:0];
      ram_wdata = ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      idx_q   <= '0;
      first_q <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      // a word loaded in SFin takes over the register instead
      if (ovld_q && out_o.ready && (state_q != SFin)) begin
        ovld_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (accept) begin
            idx_q     <= '0;
            res_val_q <= '0;
            res_ok_q  <= 1'b0;
            if (in_i.action == ActEnq) begin
              if (is_full) begin
                res_st_q <= StFull;
              end else begin
                res_st_q <= StDone;
                cnt_q    <= cnt_q + CntW'(1);
              end
              state_q <= SFin;
            end else if (cnt_q == '0) begin
              res_st_q <= StEmpty;
              state_q  <= SFin;
            end else begin
              res_st_q <= StDone;
              first_q  <= 1'b1;
              state_q  <= SScan;
            end
          end
        end
        SScan: begin
          if (take) begin
            best_pri_q <= rd_pri;
            best_val_q <= rd_val;
            best_idx_q <= idx_q;
          end
          first_q <= 1'b0;
          idx_q   <= idx_q + CntW'(1);
          if (last_hit) begin
            state_q <= SShSet;
          end
        end
        SShSet: begin
          idx_q   <= best_idx_q;
          state_q <= SShift;
        end
        SShift: begin
          if (last_hit) begin
            cnt_q     <= last_idx;
            res_val_q <= best_val_q;
            res_ok_q  <= 1'b1;
            res_st_q  <= StDone;
            state_q   <= SFin;
          end else begin
            idx_q <= idx_q + CntW'(1);
          end
        end
        SFin: begin
          if (!ovld_q || out_o.ready) begin
            ovld_q  <= 1'b1;
            oval_q  <= res_val_q;
            ook_q   <= res_ok_q;
            ost_q   <= res_st_q;
            ocnt_q  <= HeldW'(cnt_q);
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign out_o.valid      = ovld_q;
  assign out_o.out_value  = oval_q;
  assign out_o.out_valid  = ook_q;
  assign out_o.status     = ost_q;
  assign out_o.held_count = ocnt_q;

  // count never passes the table size
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count above table size");

  // the table is never written during the scan or hand-off
  a_no_wr_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == SIdle || state_q == SShift))
    else $error("table write outside enqueue or shift");

  // end of shift removes exactly one entry
  a_deq_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SShift && last_hit) |=> (cnt_q == $past(cnt_q) - CntW'(1)))
    else $error("dequeue did not remove one entry");

  // a returned value always carries done status
  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.out_valid) |-> (out_o.status == StDone))
    else $error("returned value with error status");

  // scan only runs on a non-empty table
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SScan) |-> (cnt_q != '0))
    else $error("scan on empty table");

endmodule

### rtl/apq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module apq_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### tb/tb_array_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_array_priority_queue_top: self-checking bench for the array priority queue
// Drives enqueue/dequeue words through the request channel, keeps its own
// arrival-ordered table to work out every response, and checks each response
// word field by field. A short directed table comes first, then random
// fill/drain/mixed phases with bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module tb_array_priority_queue_top;
  import apq_pkg::*;

  localparam int unsigned Depth      = DEFAULT_DEPTH;
  localparam int          TotalWords = 1550;
  // long response hold-off, to fill the result register and stall requests
  localparam int          HoldCycles = 600;
  // worst quiet stretch: the hold-off, a full scan plus shift, sender gaps
  localparam int          IdleLimit  = 4 * (HoldCycles + 2 * Depth + 64);
  localparam int          TailCycles = 2 * Depth + 8;

  localparam logic [ValW-1:0] IntMin  = 32'h8000_0000;
  localparam logic [ValW-1:0] IntMax  = 32'h7FFF_FFFF;
  localparam logic [ValW-1:0] AllOnes = 32'hFFFF_FFFF;

  // request mix of one random phase
  typedef enum logic [1:0] {
    MixFill,
    MixDrain,
    MixBalanced
  } mix_e;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic [PriW-1:0] prio;
  } slot_t;

  typedef struct packed {
    logic [ValW-1:0]  out_value;
    logic             out_valid;
    status_e          status;
    logic [HeldW-1:0] held_count;
  } response_t;

  // one directed word; when hand_typed is set the response is taken from
  // the row rather than from the bench's own table
  typedef struct packed {
    logic            act;
    logic [ValW-1:0] val;
    logic [PriW-1:0] pri;
    logic            hand_typed;
    response_t       want;
  } dir_row_t;

  localparam int NumDirRows = 23;
  localparam dir_row_t DirRows [NumDirRows] = '{
    // dequeue straight after reset: nothing held
    '{ActDeq, 32'd0, 32'd0, 1'b1, '{32'd0, 1'b0, StEmpty, 8'd0}},
    // lowest priority alone must still be found
    '{ActEnq, IntMax, IntMin, 1'b1, '{32'd0, 1'b0, StDone, 8'd1}},
    '{ActDeq, 32'd0, 32'd0, 1'b1, '{IntMax, 1'b1, StDone, 8'd0}},
    '{ActDeq, 32'd0, 32'd0, 1'b1, '{32'd0, 1'b0, StEmpty, 8'd0}},
    // tie at the lowest priority: first arrival goes out first
    '{ActEnq, IntMin, IntMin, 1'b1, '{32'd0, 1'b0, StDone, 8'd1}},
    '{ActEnq, 32'd1, IntMin, 1'b1, '{32'd0, 1'b0, StDone, 8'd2}},
    '{ActDeq, 32'd0, 32'd0, 1'b1, '{IntMin, 1'b1, StDone, 8'd1}},
    '{ActDeq, 32'd0, 32'd0, 1'b1, '{32'd1, 1'b1, StDone, 8'd0}},
    // mixed table: winner in the middle, ties, shift-down of later slots
    '{ActEnq, 32'd10, 32'd5, 1'b1, '{32'd0, 1'b0, StDone, 8'd1}},
    '{ActEnq, 32'd20, AllOnes, 1'b1, '{32'd0, 1'b0, StDone, 8'd2}},
    '{ActEnq, 32'd30, IntMax, 1'b1, '{32'd0, 1'b0, StDone, 8'd3}},
    '{ActEnq, 32'd40, 32'd5, 1'b1, '{32'd0, 1'b0, StDone, 8'd4}},
    '{ActEnq, AllOnes, 32'd0, 1'b1, '{32'd0, 1'b0, StDone, 8'd5}},
    '{ActDeq, 32'd0, 32'd0, 1'b1, '{32'd30, 1'b1, StDone, 8'd4}},
    '{ActDeq, 32'd0, 32'd0, 1'b1, '{32'd10, 1'b1, StDone, 8'd3}},
    '{ActDeq, 32'd0, 32'd0, 1'b1, '{32'd40, 1'b1, StDone, 8'd2}},
    '{ActDeq, 32'd0, 32'd0, 1'b1, '{AllOnes, 1'b1, StDone, 8'd1}},
    '{ActEnq, 32'd0, AllOnes, 1'b1, '{32'd0, 1'b0, StDone, 8'd2}},
    '{ActDeq, 32'd0, 32'd0, 1'b1, '{32'd20, 1'b1, StDone, 8'd1}},
    '{ActDeq, 32'd0, 32'd0, 1'b1, '{32'd0, 1'b1, StDone, 8'd0}},
    // dequeue fields are don't-care, even at their extremes
    '{ActDeq, IntMax, IntMax, 1'b1, '{32'd0, 1'b0, StEmpty, 8'd0}},
    '{ActEnq, 32'h5A5A_A5A5, 32'h0F0F_F0F0, 1'b0, '{32'd0, 1'b0, StDone, 8'd0}},
    '{ActDeq, 32'hA5A5_5A5A, 32'hF0F0_0F0F, 1'b0, '{32'd0, 1'b0, StDone, 8'd0}}
  };

  logic clk_i;
  logic rst_ni;

  apq_in_if  in_if ();
  apq_out_if out_if ();

  array_priority_queue_top #(
    .DEPTH (Depth)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // bench copy of the table, in arrival order, and responses still owed
  slot_t     held_q[$];
  response_t pending_q[$];

  int fail_count    = 0;
  int words_sent    = 0;
  int burst_left    = 0;
  bit quiet_phase   = 1'b0;
  bit sink_hold_req = 1'b0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin : reset_gen
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Applies one request word to the bench table and returns the response.
  // Scan keeps the first slot on equal priority, so the earliest arrival wins.
  function automatic response_t serve_request(logic act, logic [ValW-1:0] val,
                                              logic [PriW-1:0] pri);
    response_t rsp;
    int        best;
    rsp = '{out_value: '0, out_valid: 1'b0, status: StDone, held_count: '0};
    if (act == ActEnq) begin
      if (held_q.size() >= Depth) begin
        rsp.status = StFull;
      end else begin
        held_q.push_back('{value: val, prio: pri});
      end
    end else if (held_q.size() == 0) begin
      rsp.status = StEmpty;
    end else begin
      best = 0;
      for (int i = 1; i < held_q.size(); i++) begin
        if ($signed(held_q[i].prio) > $signed(held_q[best].prio)) best = i;
      end
      rsp.out_value = held_q[best].value;
      rsp.out_valid = 1'b1;
      held_q.delete(best);
    end
    rsp.held_count = HeldW'(held_q.size());
    return rsp;
  endfunction

  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return IntMin;
      1:       return IntMax;
      2:       return '0;
      3:       return AllOnes;
      default: return $urandom();
    endcase
  endfunction

  // priorities lean on a narrow band around zero so that ties are common
  function automatic logic [PriW-1:0] pick_priority();
    case ($urandom_range(0, 11))
      0:             return IntMin;
      1:             return IntMax;
      2, 3, 4, 5, 6: return PriW'($urandom_range(0, 7)) - PriW'(4);
      default:       return $urandom();
    endcase
  endfunction

  // Offers one word from a falling edge, waits for it to be taken, books the
  // response and returns on the next falling edge.
  task automatic send_word(input logic act, input logic [ValW-1:0] val,
                           input logic [PriW-1:0] pri, input logic hand_typed,
                           input response_t typed_rsp);
    response_t rsp;
    in_if.valid         <= 1'b1;
    in_if.action        <= act;
    in_if.item_value    <= val;
    in_if.item_priority <= pri;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    rsp = serve_request(act, val, pri);
    pending_q.push_back(hand_typed ? typed_rsp : rsp);
    words_sent++;
    @(negedge clk_i);
  endtask

  // bursts of back-to-back words split by random gaps, none in a quiet phase
  task automatic maybe_idle();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = quiet_phase ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // stop offering until every booked response has come back
  task automatic drain_responses();
    in_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : source_side
    mix_e        mode;
    int          phase;
    int          phase_len;
    int          deq_pct;
    logic        act;
    response_t   no_rsp;
    no_rsp = '{out_value: '0, out_valid: 1'b0, status: StDone, held_count: '0};
    in_if.valid         <= 1'b0;
    in_if.action        <= ActEnq;
    in_if.item_value    <= '0;
    in_if.item_priority <= '0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);

    for (int i = 0; i < NumDirRows; i++) begin
      send_word(DirRows[i].act, DirRows[i].val, DirRows[i].pri,
                DirRows[i].hand_typed, DirRows[i].want);
      maybe_idle();
    end
    drain_responses();

    // Random phases. Fill phases mostly enqueue, to run the table toward full, drain
    // phases mostly dequeue, to run it dry; one long fill goes with the response hold-off.
    phase = 0;
    while (words_sent < TotalWords) begin
      mode        = mix_e'($urandom_range(0, 2));
      phase_len   = $urandom_range(16, 160);
      quiet_phase = ($urandom_range(0, 3) == 0);
      if (phase == 1) begin
        mode          = MixFill;
        phase_len     = 200;
        sink_hold_req = 1'b1;
      end
      if (phase_len > TotalWords - words_sent) phase_len = TotalWords - words_sent;
      if (phase == 6) drain_responses();
      case (mode)
        MixFill:  deq_pct = 10;
        MixDrain: deq_pct = 90;
        default:  deq_pct = 50;
      endcase
      repeat (phase_len) begin
        act = ($urandom_range(1, 100) <= deq_pct) ? ActDeq : ActEnq;
        send_word(act, pick_value(), pick_priority(), 1'b0, no_rsp);
        maybe_idle();
      end
      phase++;
    end

    drain_responses();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Response side: ready follows segments of differing stall density, with
  // one long hold-off on request from the source side.
  initial begin : sink_side
    int seg_len;
    int ready_pct;
    out_if.ready <= 1'b0;
    forever begin
      seg_len = $urandom_range(4, 48);
      case ($urandom_range(0, 3))
        0:       ready_pct = 100;
        1:       ready_pct = 30;
        2:       ready_pct = 70;
        default: ready_pct = 90;
      endcase
      repeat (seg_len) begin
        @(negedge clk_i);
        if (sink_hold_req) begin
          out_if.ready <= 1'b0;
          repeat (HoldCycles) @(negedge clk_i);
          sink_hold_req = 1'b0;
        end
        out_if.ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  function automatic void report_field(string name, logic [ValW-1:0] want,
                                       logic [ValW-1:0] got);
    $error("%s: expected %0h, got %0h", name, want, got);
    fail_count++;
  endfunction

  // every accepted response word is matched against the oldest booked one
  always @(posedge clk_i) begin : response_check
    response_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_q.size() == 0) begin
        $error("response word with none outstanding: value %0h status %0d",
               out_if.out_value, out_if.status);
        fail_count++;
      end else begin
        want = pending_q.pop_front();
        if (out_if.out_value !== want.out_value)
          report_field("out_value", want.out_value, out_if.out_value);
        if (out_if.out_valid !== want.out_valid)
          report_field("out_valid", ValW'(want.out_valid), ValW'(out_if.out_valid));
        if (out_if.status !== want.status)
          report_field("status", ValW'(want.status), ValW'(out_if.status));
        if (out_if.held_count !== want.held_count)
          report_field("held_count", ValW'(want.held_count), ValW'(out_if.held_count));
      end
    end
  end

  // ends a hung run: too long with no word moving on either channel
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
